@@ rtl/mrct_pkg.sv @@
// shared types, codes and constants for the request credit throttle
// no dependencies; used by every other file of the block but mrct_ram
package mrct_pkg;

  // field widths
  localparam int CMD_W    = 2;
  localparam int ID_W     = 6;
  localparam int SIZE_W   = 16;
  localparam int CHARGE_W = SIZE_W + 1;
  localparam int BYTES_W  = 20;
  localparam int MAXOUT_W = 8;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 3;
  localparam int CFG_INDEX_W = 2;

  // id space that the request_id field can name
  localparam int ID_COUNT = 2 ** ID_W;

  // default number of ids that the block tracks
  localparam int NUM_IDS_DEFAULT = 64;

  // fixed overhead charged per request, reset values, counter ceiling
  localparam logic [CHARGE_W-1:0] OVERHEAD_BYTES = CHARGE_W'(8);
  localparam logic [BYTES_W-1:0]  CAPACITY_RESET = BYTES_W'(4200);
  localparam logic [MAXOUT_W-1:0] MAX_OUT_RESET  = MAXOUT_W'(20);
  localparam logic [COUNT_W-1:0]  COUNT_LIMIT    = COUNT_W'(127);

  // command codes
  localparam logic [CMD_W-1:0] CMD_ADMIT    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_COMPLETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_ROOM   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_COMPLETED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MEMORY_CAPACITY = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_OUTSTANDING = 2'd1;

  // one input word
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   request_id;
    logic [SIZE_W-1:0] required_size;
  } item_t;

  // one result word
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTES_W-1:0]  free_memory;
    logic [COUNT_W-1:0]  outstanding_count;
  } result_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;  // capture the input word and start the table read
    logic exec;  // table data is ready: decide and update the state
  } ctl_t;

endpackage

@@ rtl/memory_and_request_credit_throttle.sv @@
// top level of the request credit throttle
// depends on mrct_pkg, mrct_ctrl, mrct_datapath, mrct_ram
//
// Each command word goes through two steps: capture it and read the per-id
// charge memory, then decide and update the counters. The result appears
// with done high for exactly one cycle after that, and since the receiver
// cannot stall, a new word may be started in that same cycle. The block
// accepts no new word while one is in flight. Configuration writes are
// always ready; write them only while the block is idle.
module memory_and_request_credit_throttle #(
  parameter int NUM_IDS = mrct_pkg::NUM_IDS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  mrct_pkg::item_t                   item,
  output logic                              busy,
  output logic                              done,
  output mrct_pkg::result_t                 result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mrct_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mrct_pkg::BYTES_W-1:0]      cfg_data
);

  mrct_pkg::ctl_t ctl;

  assign cfg_ready = 1'b1;

  // sequencing
  mrct_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl)
  );

  // state and arithmetic
  mrct_datapath #(
    .NUM_IDS (NUM_IDS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

endmodule

@@ rtl/mrct_ram.sv @@
// generic single-write, single-read memory with registered read data
// no dependencies
module mrct_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/mrct_ctrl.sv @@
// controller: sequences one command word through lookup and execute
// depends on mrct_pkg
module mrct_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  output logic             done,
  output mrct_pkg::ctl_t   ctl
);

  typedef enum logic {
    IDLE,
    EXEC
  } state_t;

  state_t state;

  // state and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (start) begin
            state <= EXEC;
          end
        end
        EXEC: begin
          state <= IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // commands to the datapath
  assign busy     = (state != IDLE);
  assign ctl.load = start && (state == IDLE);
  assign ctl.exec = (state == EXEC);

endmodule

@@ rtl/mrct_datapath.sv @@
// datapath: config registers, per-id valid bits and charge table, counters
// depends on mrct_pkg and mrct_ram
module mrct_datapath #(
  parameter int NUM_IDS = mrct_pkg::NUM_IDS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mrct_pkg::ctl_t                      ctl,
  input  mrct_pkg::item_t                     item,
  input  logic                                cfg_valid,
  input  logic [mrct_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mrct_pkg::BYTES_W-1:0]        cfg_data,
  output mrct_pkg::result_t                   result
);

  // only ids the input field can name need storage
  localparam int Entries = (NUM_IDS < mrct_pkg::ID_COUNT) ? NUM_IDS : mrct_pkg::ID_COUNT;
  localparam int IdxW    = $clog2(Entries);
  localparam bit AllInRange = (NUM_IDS >= mrct_pkg::ID_COUNT);

  logic [mrct_pkg::BYTES_W-1:0]  capacity;
  logic [mrct_pkg::MAXOUT_W-1:0] max_out;
  logic [mrct_pkg::BYTES_W-1:0]  occupied;
  logic [mrct_pkg::COUNT_W-1:0]  outstanding;
  logic [Entries-1:0]            entry_valid;
  logic [mrct_pkg::STATUS_W-1:0] status;

  logic [mrct_pkg::CMD_W-1:0]    cmd;
  logic [mrct_pkg::ID_W-1:0]     req_id;
  logic [mrct_pkg::CHARGE_W-1:0] need;

  logic [mrct_pkg::CHARGE_W-1:0] charge_rd;
  logic                          charge_we;
  logic [IdxW-1:0]               idx;
  logic                          in_range;
  logic                          hit;
  logic                          room;
  logic [mrct_pkg::BYTES_W:0]    occ_plus;
  logic [mrct_pkg::BYTES_W:0]    occ_minus;

  // configuration registers, always ready
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= mrct_pkg::CAPACITY_RESET;
      max_out  <= mrct_pkg::MAX_OUT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        mrct_pkg::REG_MEMORY_CAPACITY: capacity <= cfg_data;
        mrct_pkg::REG_MAX_OUTSTANDING: max_out  <= cfg_data[mrct_pkg::MAXOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // capture the command word, charge includes the fixed overhead
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd    <= item.cmd;
      req_id <= item.request_id;
      need   <= mrct_pkg::CHARGE_W'(item.required_size) + mrct_pkg::OVERHEAD_BYTES;
    end
  end

  // charge per id, read during the load cycle
  mrct_ram #(
    .Width (mrct_pkg::CHARGE_W),
    .Depth (Entries)
  ) u_charge_ram (
    .clk   (clk),
    .we    (charge_we),
    .waddr (idx),
    .wdata (need),
    .re    (ctl.load),
    .raddr (item.request_id[IdxW-1:0]),
    .rdata (charge_rd)
  );

  // lookup and admission checks
  assign idx       = req_id[IdxW-1:0];
  assign in_range  = AllInRange || (32'(req_id) < NUM_IDS);
  assign hit       = in_range && entry_valid[idx];
  assign occ_plus  = {1'b0, occupied} + (mrct_pkg::BYTES_W + 1)'(need);
  assign occ_minus = {1'b0, occupied} - (mrct_pkg::BYTES_W + 1)'(charge_rd);
  assign room      = ({1'b0, capacity} >= occ_plus)
                     && ({1'b0, outstanding} < max_out)
                     && (outstanding < mrct_pkg::COUNT_LIMIT);
  assign charge_we = ctl.exec && (cmd == mrct_pkg::CMD_ADMIT) && in_range && !hit && room;

  // state update and status
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      occupied    <= '0;
      outstanding <= '0;
      status      <= mrct_pkg::ST_UNKNOWN;
    end else if (ctl.exec) begin
      case (cmd)
        mrct_pkg::CMD_ADMIT: begin
          if (!in_range) begin
            status <= mrct_pkg::ST_UNKNOWN;
          end else if (hit) begin
            status <= mrct_pkg::ST_DUPLICATE;
          end else if (room) begin
            entry_valid[idx] <= 1'b1;
            occupied         <= occ_plus[mrct_pkg::BYTES_W-1:0];
            outstanding      <= outstanding + mrct_pkg::COUNT_W'(1);
            status           <= mrct_pkg::ST_GRANTED;
          end else begin
            status <= mrct_pkg::ST_NO_ROOM;
          end
        end
        mrct_pkg::CMD_COMPLETE: begin
          if (hit) begin
            entry_valid[idx] <= 1'b0;
            // borrow means the charge exceeds occupancy: floor at zero
            occupied <= occ_minus[mrct_pkg::BYTES_W] ? '0
                                                     : occ_minus[mrct_pkg::BYTES_W-1:0];
            if (outstanding != '0) begin
              outstanding <= outstanding - mrct_pkg::COUNT_W'(1);
            end
            status <= mrct_pkg::ST_COMPLETED;
          end else begin
            status <= mrct_pkg::ST_UNKNOWN;
          end
        end
        mrct_pkg::CMD_CLEAR: begin
          entry_valid <= '0;
          occupied    <= '0;
          outstanding <= '0;
          status      <= mrct_pkg::ST_CLEARED;
        end
        default: begin
          status <= mrct_pkg::ST_UNKNOWN;
        end
      endcase
    end
  end

  // result word: free memory floored at zero
  assign result.status            = status;
  assign result.free_memory       = (capacity > occupied) ? capacity - occupied : '0;
  assign result.outstanding_count = outstanding;

endmodule

@@ rtl/mrct_checker.sv @@
// port-level checks for the request credit throttle, bound to the top level
// depends on mrct_pkg
module mrct_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input mrct_pkg::result_t result
);

  // an accepted word makes the block busy
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // every accepted word is followed by its result strobe
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |-> ##2 done)
    else $error("result missing after accepted word");

  // results only come out while idle
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // status is one of the defined codes
  assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status <= mrct_pkg::ST_CLEARED))
    else $error("undefined status code");

  // clear leaves nothing outstanding, and no more than the id space otherwise
  assert property (@(posedge clk) disable iff (rst)
    done |-> ((result.status != mrct_pkg::ST_CLEARED) || (result.outstanding_count == '0))
             && (result.outstanding_count <= mrct_pkg::COUNT_W'(mrct_pkg::ID_COUNT)))
    else $error("outstanding count out of bounds");

endmodule

bind memory_and_request_credit_throttle mrct_checker u_mrct_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
